[rtl/core/dvad_pkg.sv]
// Shared types, constants and calendar functions for the date check and day adder.
// Depends on nothing; the front, queue, back, top and checker use it by scoped names.
`default_nettype none

package dvad_pkg;

    localparam logic [13:0] MAX_YEAR        = 14'd9999;
    localparam logic [8:0]  MAX_OFFSET      = 9'd365;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
    localparam logic [3:0]  M_JAN           = 4'd1;
    localparam logic [3:0]  M_FEB           = 4'd2;
    localparam logic [3:0]  M_APR           = 4'd4;
    localparam logic [3:0]  M_JUN           = 4'd6;
    localparam logic [3:0]  M_SEP           = 4'd9;
    localparam logic [3:0]  M_NOV           = 4'd11;
    localparam logic [4:0]  LEN_LONG        = 5'd31;
    localparam logic [4:0]  LEN_SHORT       = 5'd30;
    localparam logic [4:0]  LEN_FEB_LEAP    = 5'd29;
    localparam logic [4:0]  LEN_FEB         = 5'd28;

    // Exact divisibility by 25 over 14 bits: y * inverse(25) mod 2^14 <= (2^14-1)/25.
    localparam logic [13:0] INV25           = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT     = 14'd655;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_MONTH   = 3'd1,
        ERR_WEEKDAY = 3'd2,
        ERR_DAY     = 3'd3,
        ERR_OFFSET  = 3'd4,
        ERR_YEAR    = 3'd5
    } dvad_err_t;

    typedef struct packed {
        dvad_err_t   err;
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month_num;
        logic [13:0] year_num;
        logic [8:0]  offset_days;
    } dvad_entry_t;

    typedef struct packed {
        logic        push;
        dvad_entry_t entry;
    } dvad_qwr_t;

    typedef struct packed {
        logic        valid;
        dvad_entry_t entry;
    } dvad_qrd_t;

    typedef struct packed {
        dvad_err_t   error_code;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic [2:0]  weekday_out;
    } dvad_result_t;

    // Gregorian rule: by 4 and not by 100, or by 400 (100 = 4*25, 400 = 16*25).
    function automatic logic is_leap(input logic [13:0] year);
        logic [27:0] prod;
        logic        by25;
        logic        by4;
        logic        by16;
        prod = 28'(year) * 28'(INV25);
        by25 = (prod[13:0] <= DIV25_LIMIT);
        by4  = (year[1:0] == 2'd0);
        by16 = (year[3:0] == 4'd0);
        return by4 && (!by25 || by16);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            M_FEB:   len = leap ? LEN_FEB_LEAP : LEN_FEB;
            M_APR:   len = LEN_SHORT;
            M_JUN:   len = LEN_SHORT;
            M_SEP:   len = LEN_SHORT;
            M_NOV:   len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dvad_item_if.sv]
// Input channel of the date check and day adder: valid/ready plus the date fields.
// Depends on nothing.
`default_nettype none

interface dvad_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month_num;
    logic [13:0] year_num;
    logic [8:0]  offset_days;

    modport source (
        output valid, weekday, day_of_month, month_num, year_num, offset_days,
        input  ready
    );
    modport sink (
        input  valid, weekday, day_of_month, month_num, year_num, offset_days,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/dvad_result_if.sv]
// Result channel of the date check and day adder: valid/ready plus the result fields.
// Depends on nothing.
`default_nettype none

interface dvad_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic [2:0]  weekday_out;

    modport source (
        output valid, error_code, new_day, new_month, new_year, weekday_out,
        input  ready
    );
    modport sink (
        input  valid, error_code, new_day, new_month, new_year, weekday_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/dvad_front.sv]
// Front end: accepts input beats and classifies each date into an error code.
// Depends on dvad_pkg and dvad_item_if.
`default_nettype none

module dvad_front (
    dvad_item_if.sink        item,
    input  wire logic        q_full,
    output dvad_pkg::dvad_qwr_t q_wr
);

    logic              leap;
    logic [4:0]        len;
    logic              month_ok;
    logic              wday_ok;
    logic              day_ok;
    dvad_pkg::dvad_err_t err;

    always_comb
    begin
        leap     = dvad_pkg::is_leap(item.year_num);
        len      = dvad_pkg::month_length(item.month_num, leap);
        month_ok = (item.month_num >= dvad_pkg::M_JAN)
                && (item.month_num <= dvad_pkg::MONTHS_PER_YEAR);
        wday_ok  = (item.weekday != 3'd0) && (item.weekday <= dvad_pkg::DAYS_PER_WEEK);
        day_ok   = (item.day_of_month != 5'd0) && (item.day_of_month <= len);

        // Lowest code wins: month, weekday, day, offset.
        if (!month_ok)
            err = dvad_pkg::ERR_MONTH;
        else if (!wday_ok)
            err = dvad_pkg::ERR_WEEKDAY;
        else if (!day_ok)
            err = dvad_pkg::ERR_DAY;
        else if (item.offset_days > dvad_pkg::MAX_OFFSET)
            err = dvad_pkg::ERR_OFFSET;
        else
            err = dvad_pkg::ERR_OK;
    end

    assign item.ready = !q_full;

    always_comb
    begin
        q_wr.push               = item.valid && !q_full;
        q_wr.entry.err          = err;
        q_wr.entry.weekday      = item.weekday;
        q_wr.entry.day_of_month = item.day_of_month;
        q_wr.entry.month_num    = item.month_num;
        q_wr.entry.year_num     = item.year_num;
        q_wr.entry.offset_days  = item.offset_days;
    end

endmodule

`default_nettype wire

[rtl/core/dvad_queue.sv]
// Short FIFO between front and back end, holding classified entries.
// Depends on dvad_pkg.
`default_nettype none

module dvad_queue #(
    parameter int DEPTH = dvad_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dvad_pkg::dvad_qwr_t q_wr,
    input  wire logic               pop,
    output dvad_pkg::dvad_qrd_t     q_rd,
    output logic                    full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    dvad_pkg::dvad_entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_pop;

    assign full   = (count_reg == CW'(DEPTH));
    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem[wr_ptr_reg] <= q_wr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            case ({q_wr.push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign q_rd = {(count_reg != '0), mem[rd_ptr_reg]};

endmodule

`default_nettype wire

[rtl/core/dvad_back.sv]
// Back end: carries whole months out of day+offset, one month per cycle,
// and holds the result in an output register. Depends on dvad_pkg, dvad_result_if.
`default_nettype none

module dvad_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dvad_pkg::dvad_qrd_t q_rd,
    output logic                    pop,
    dvad_result_if.source           result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                 state_reg;
    logic [8:0]             res_reg;
    logic [3:0]             month_reg;
    logic [14:0]            year_reg;
    logic [2:0]             wday_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    dvad_pkg::dvad_result_t out_reg;

    logic [4:0] len;
    logic       fits;
    logic       slot_free;

    always_comb
    begin
        len       = dvad_pkg::month_length(month_reg, dvad_pkg::is_leap(year_reg[13:0]));
        fits      = (res_reg <= {4'd0, len});
        slot_free = !out_valid_reg || result.ready;
        pop       = (state_reg == ST_IDLE) && q_rd.valid && slot_free;

        // Drop the result once taken; raise it when a new one loads.
        out_valid_next = out_valid_reg && !result.ready;
        if (pop && (q_rd.entry.err != dvad_pkg::ERR_OK))
            out_valid_next = 1'b1;
        if ((state_reg == ST_RUN) && fits && slot_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            wday_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_rd.entry.err != dvad_pkg::ERR_OK)
                        begin
                            out_reg.error_code  <= q_rd.entry.err;
                            out_reg.new_day     <= '0;
                            out_reg.new_month   <= '0;
                            out_reg.new_year    <= '0;
                            out_reg.weekday_out <= q_rd.entry.weekday;
                        end
                        else
                        begin
                            res_reg   <= {4'd0, q_rd.entry.day_of_month}
                                       + q_rd.entry.offset_days;
                            month_reg <= q_rd.entry.month_num;
                            year_reg  <= {1'b0, q_rd.entry.year_num};
                            wday_reg  <= q_rd.entry.weekday;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (!fits)
                    begin
                        // Carry one month.
                        res_reg <= res_reg - {4'd0, len};
                        if (month_reg == dvad_pkg::MONTHS_PER_YEAR)
                        begin
                            month_reg <= dvad_pkg::M_JAN;
                            year_reg  <= year_reg + 1'b1;
                        end
                        else
                            month_reg <= month_reg + 1'b1;
                    end
                    else if (slot_free)
                    begin
                        out_reg.weekday_out <= wday_reg;
                        if (year_reg > {1'b0, dvad_pkg::MAX_YEAR})
                        begin
                            out_reg.error_code <= dvad_pkg::ERR_YEAR;
                            out_reg.new_day    <= '0;
                            out_reg.new_month  <= '0;
                            out_reg.new_year   <= '0;
                        end
                        else
                        begin
                            out_reg.error_code <= dvad_pkg::ERR_OK;
                            out_reg.new_day    <= res_reg[4:0];
                            out_reg.new_month  <= month_reg;
                            out_reg.new_year   <= year_reg[13:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.error_code  = out_reg.error_code;
    assign result.new_day     = out_reg.new_day;
    assign result.new_month   = out_reg.new_month;
    assign result.new_year    = out_reg.new_year;
    assign result.weekday_out = out_reg.weekday_out;

endmodule

`default_nettype wire

[rtl/core/date_validate_and_add_days_core.sv]
// Top level of the Gregorian date check and day adder.
// Depends on dvad_pkg, dvad_item_if, dvad_result_if, dvad_front, dvad_queue, dvad_back.
//
// Usage:
//   item   - input channel (valid/ready): weekday, day_of_month, month_num,
//            year_num, offset_days. A beat moves on a clock edge with valid and
//            ready both high.
//   result - output channel (valid/ready): error_code, new_day, new_month,
//            new_year, weekday_out. One result beat per input beat, in order.
//   The front end checks the date as it is taken and writes it into a short
//   queue; item.ready drops only while that queue is full. The back end takes
//   one entry at a time and carries one whole month per cycle.
//   Each entry leaves the queue only once the output register is free. A date
//   rejected by the front end goes straight into it; a valid date enters ST_RUN,
//   makes k month carries (k <= 13), then loads it when it is free again. Each
//   input beat passes through the queue first and may wait behind earlier items.
//   When result.ready is low, the result holds in the output register, the
//   back end waits, and the queue keeps taking input beats until it fills.
//   Reset empties the queue and the output register; there is no clearing pass.
`default_nettype none

module date_validate_and_add_days_core #(
    parameter int QUEUE_DEPTH = dvad_pkg::QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dvad_item_if.sink     item,
    dvad_result_if.source result
);

    dvad_pkg::dvad_qwr_t q_wr;
    dvad_pkg::dvad_qrd_t q_rd;
    logic                q_full;
    logic                pop;

    // Classify and push.
    dvad_front u_front (
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    // Decouple front from back.
    dvad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    // Carry months and drive the result register.
    dvad_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (pop),
        .result (result)
    );

    // Never write into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full)
        else $error("queue written while full");

    // Never pop an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_rd.valid)
        else $error("queue popped while empty");

    // An error result carries a cleared date.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.error_code != dvad_pkg::ERR_OK))
        |-> (result.new_day == 5'd0) && (result.new_month == 4'd0)
            && (result.new_year == 14'd0))
        else $error("error result with nonzero date");

    // A good result has a valid month, a nonzero day and a year within range.
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.error_code == dvad_pkg::ERR_OK))
        |-> (result.new_month >= dvad_pkg::M_JAN)
            && (result.new_month <= dvad_pkg::MONTHS_PER_YEAR)
            && (result.new_day != 5'd0)
            && (result.new_year <= dvad_pkg::MAX_YEAR))
        else $error("good result out of range");

endmodule

`default_nettype wire

[verif/dvad_date_checker.sv]
// Checker for the date check and day adder: watches both channels, predicts each result.
// Depends on dvad_pkg, dvad_item_if and dvad_result_if.

module dvad_date_checker (
    input  logic   clk,
    input  logic   rst_n,
    dvad_item_if   item,
    dvad_result_if result,
    output int     fail_count,
    output int     dates_in_flight
);

    dvad_pkg::dvad_result_t projected_dates[$];
    dvad_pkg::dvad_result_t want;
    int                     mismatches = 0;

    function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
        logic leap;
        leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
        if (mon == dvad_pkg::M_FEB)
            return leap ? dvad_pkg::LEN_FEB_LEAP : dvad_pkg::LEN_FEB;
        if (mon == dvad_pkg::M_APR || mon == dvad_pkg::M_JUN ||
            mon == dvad_pkg::M_SEP || mon == dvad_pkg::M_NOV)
            return dvad_pkg::LEN_SHORT;
        return dvad_pkg::LEN_LONG;
    endfunction

    // Validate the date, then add the offset and carry whole months until the day fits.
    function automatic dvad_pkg::dvad_result_t project_date(
        input logic [2:0]  wd,
        input logic [4:0]  dom,
        input logic [3:0]  mon_in,
        input logic [13:0] yr_in,
        input logic [8:0]  add
    );
        dvad_pkg::dvad_result_t r;
        int unsigned            total;
        int unsigned            mon;
        int unsigned            yr;
        r             = '0;
        r.weekday_out = wd;
        r.error_code  = dvad_pkg::ERR_OK;
        if (mon_in < dvad_pkg::M_JAN || mon_in > dvad_pkg::MONTHS_PER_YEAR)
            r.error_code = dvad_pkg::ERR_MONTH;
        else if (wd == 3'd0 || wd > dvad_pkg::DAYS_PER_WEEK)
            r.error_code = dvad_pkg::ERR_WEEKDAY;
        else if (dom == 5'd0 || dom > days_in_month(mon_in, yr_in))
            r.error_code = dvad_pkg::ERR_DAY;
        else if (add > dvad_pkg::MAX_OFFSET)
            r.error_code = dvad_pkg::ERR_OFFSET;
        else begin
            total = dom + add;
            mon   = mon_in;
            yr    = yr_in;
            while (total > days_in_month(mon, yr)) begin
                total = total - days_in_month(mon, yr);
                mon   = mon + 1;
                if (mon > dvad_pkg::MONTHS_PER_YEAR) begin
                    mon = dvad_pkg::M_JAN;
                    yr  = yr + 1;
                end
            end
            if (yr > dvad_pkg::MAX_YEAR)
                r.error_code = dvad_pkg::ERR_YEAR;
            else begin
                r.new_day   = total[4:0];
                r.new_month = mon[3:0];
                r.new_year  = yr[13:0];
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [13:0] exp_v,
                                 input logic [13:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (item.valid && item.ready)
                projected_dates.push_back(project_date(item.weekday, item.day_of_month,
                                                       item.month_num, item.year_num,
                                                       item.offset_days));
            if (result.valid && result.ready) begin
                if (projected_dates.size() == 0) begin
                    $error("result beat with no date pending");
                    mismatches++;
                end
                else begin
                    want = projected_dates.pop_front();
                    compare_field("error_code", 14'(want.error_code), 14'(result.error_code));
                    compare_field("new_day", 14'(want.new_day), 14'(result.new_day));
                    compare_field("new_month", 14'(want.new_month), 14'(result.new_month));
                    compare_field("new_year", want.new_year, result.new_year);
                    compare_field("weekday_out", 14'(want.weekday_out),
                                  14'(result.weekday_out));
                end
            end
        end
        fail_count      <= mismatches;
        dates_in_flight <= projected_dates.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the Gregorian date check and day adder.
// Depends on dvad_pkg, both channel interfaces, the core and dvad_date_checker.

module tb_top;

    // Worst run: ~1225 beats, each with the longest send gap, the longest result
    // stall and the most back end work; take that several times over.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_DATES = 1200;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   dates_in_flight;
    logic gapless_sends;

    dvad_item_if   item_ch ();
    dvad_result_if result_ch ();

    date_validate_and_add_days_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    dvad_date_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .fail_count      (fail_count),
        .dates_in_flight (dates_in_flight)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drive one date beat at the falling edge, hold it until the core takes it,
    // then idle the channel for a random gap (or keep valid up for back-to-back).
    task automatic send_date(input logic [2:0] wd, input logic [4:0] dom,
                             input logic [3:0] mon, input logic [13:0] yr,
                             input logic [8:0] add);
        int gap;
        @(negedge clk);
        item_ch.valid        <= 1'b1;
        item_ch.weekday      <= wd;
        item_ch.day_of_month <= dom;
        item_ch.month_num    <= mon;
        item_ch.year_num     <= yr;
        item_ch.offset_days  <= add;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        gap = gapless_sends ? 0 : idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Build one random beat. Most are well-formed dates with random content;
    // the rest are pure noise or a good date with one field broken.
    task automatic send_random_date();
        logic [2:0]  wd;
        logic [4:0]  dom;
        logic [3:0]  mon;
        logic [13:0] yr;
        logic [8:0]  add;
        int          kind;
        int          pick;
        wd   = 3'($urandom_range(1, 7));
        mon  = 4'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            yr = 14'($urandom_range(0, 99) * 100);
        else if (pick < 20)
            yr = 14'($urandom_range(9990, 9999));
        else
            yr = 14'($urandom_range(0, 9999));
        // Month ends: some of these land past the end of short months.
        if ($urandom_range(0, 99) < 25)
            dom = 5'($urandom_range(28, 31));
        else
            dom = 5'($urandom_range(1, 28));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            add = 9'd365;
        else if (pick < 15)
            add = 9'd0;
        else
            add = 9'($urandom_range(0, 365));
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            wd  = 3'($urandom);
            dom = 5'($urandom);
            mon = 4'($urandom);
            yr  = 14'($urandom);
            add = 9'($urandom);
        end
        else if (kind < 28)
        begin
            case ($urandom_range(0, 4))
                0: mon = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
                1: wd  = 3'd0;
                2: dom = 5'd0;
                3: add = 9'($urandom_range(366, 511));
                default: yr = 14'($urandom_range(10000, 16383));
            endcase
        end
        send_date(wd, dom, mon, yr, add);
    endtask

    // Result side: ready runs of random length broken by stalls; now and then
    // a long run with no stall at all.
    initial
    begin
        int run;
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
            repeat (run)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            stall = idle_length();
            repeat (stall)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        gapless_sends        = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.weekday      = '0;
        item_ch.day_of_month = '0;
        item_ch.month_num    = '0;
        item_ch.year_num     = '0;
        item_ch.offset_days  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every error and the calendar corners.
        send_date(3'd1, 5'd1,  4'd1,  14'd2024,  9'd0);    // plain valid date
        send_date(3'd2, 5'd10, 4'd0,  14'd2024,  9'd5);    // month zero
        send_date(3'd0, 5'd0,  4'd13, 14'd2024,  9'd511);  // month wins over all
        send_date(3'd3, 5'd15, 4'd15, 14'd16383, 9'd1);    // top month code
        send_date(3'd0, 5'd0,  4'd6,  14'd2024,  9'd400);  // weekday wins over day
        send_date(3'd4, 5'd0,  4'd7,  14'd2024,  9'd1);    // day zero
        send_date(3'd5, 5'd29, 4'd2,  14'd2023,  9'd0);    // Feb 29, common year
        send_date(3'd6, 5'd29, 4'd2,  14'd2024,  9'd1);    // Feb 29, leap year
        send_date(3'd7, 5'd29, 4'd2,  14'd1900,  9'd0);    // century, not leap
        send_date(3'd1, 5'd29, 4'd2,  14'd2000,  9'd0);    // by 400, leap
        send_date(3'd2, 5'd29, 4'd2,  14'd0,     9'd0);    // year zero is leap
        send_date(3'd3, 5'd31, 4'd4,  14'd2024,  9'd0);    // past a 30-day month
        send_date(3'd4, 5'd31, 4'd1,  14'd2024,  9'd0);    // last day, long month
        send_date(3'd5, 5'd10, 4'd3,  14'd2024,  9'd366);  // offset just too big
        send_date(3'd6, 5'd31, 4'd9,  14'd2024,  9'd511);  // bad day hides offset
        send_date(3'd7, 5'd31, 4'd12, 14'd9999,  9'd1);    // carry past the last year
        send_date(3'd7, 5'd31, 4'd12, 14'd9999,  9'd0);    // last representable day
        send_date(3'd1, 5'd1,  4'd1,  14'd10000, 9'd0);    // input year too big
        send_date(3'd7, 5'd31, 4'd12, 14'd16383, 9'd365);  // all fields high
        send_date(3'd1, 5'd1,  4'd1,  14'd0,     9'd365);  // through a leap year zero
        send_date(3'd2, 5'd31, 4'd1,  14'd2023,  9'd365);  // most month carries
        send_date(3'd3, 5'd31, 4'd12, 14'd2023,  9'd365);  // across a year end
        send_date(3'd4, 5'd28, 4'd2,  14'd2023,  9'd1);    // Feb into March
        send_date(3'd5, 5'd28, 4'd2,  14'd2100,  9'd1);    // century Feb into March

        for (int n = 0; n < RANDOM_DATES; n++)
        begin
            // Switch between back-to-back bursts and gappy traffic.
            if (n % 100 == 0)
                gapless_sends = ($urandom_range(0, 3) == 0);
            send_random_date();
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // Drain: wait for every projected date, then watch for strays.
        @(posedge clk);
        while (dates_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
